// ===== sv/mtf_pkg.sv =====
// Shared types and constants for the move-to-front list table.
// Holds function codes, status codes, stream field widths and the
// command/status structs between controller and datapath. No dependencies.
package mtf_pkg;

    // Stream field widths
    localparam int FUNC_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 4;
    localparam int HEAD_W    = 32;
    localparam int COUNT_W   = 5;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (POS_W + HEAD_W + COUNT_W);

    // Request functions
    localparam logic [FUNC_W-1:0] F_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] F_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] F_REM_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] F_REM_VALUE = 3'd3;
    localparam logic [FUNC_W-1:0] F_SEARCH    = 3'd4;
    localparam logic [FUNC_W-1:0] F_MOVE      = 3'd5;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Scan pointer operations
    localparam logic [2:0] IDX_HOLD    = 3'd0;
    localparam logic [2:0] IDX_ZERO    = 3'd1;
    localparam logic [2:0] IDX_ONE     = 3'd2;
    localparam logic [2:0] IDX_TOP     = 3'd3;
    localparam logic [2:0] IDX_RD_NEXT = 3'd4;
    localparam logic [2:0] IDX_RD_PREV = 3'd5;
    localparam logic [2:0] IDX_INC     = 3'd6;
    localparam logic [2:0] IDX_DEC     = 3'd7;

    // Store write operations
    localparam logic [2:0] WR_NONE       = 3'd0;
    localparam logic [2:0] WR_VAL_HEAD   = 3'd1;
    localparam logic [2:0] WR_VAL_TAIL   = 3'd2;
    localparam logic [2:0] WR_SHIFT_UP   = 3'd3;
    localparam logic [2:0] WR_SHIFT_DOWN = 3'd4;

    // Entry count operations
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    typedef struct packed {
        logic                capture;
        logic [2:0]          idx_op;
        logic                rd_en;
        logic [2:0]          wr_op;
        logic [1:0]          cnt_op;
        logic                pos_hit;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } t_mtf_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic count_full;
        logic rd_vld;
        logic rd_match;
        logic rd_at_zero;
        logic rd_at_last;
    } t_mtf_stat;

endpackage

// ===== sv/mtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mtf_datapath.sv =====
// Datapath of the move-to-front list table: entry store, count, head copy,
// scan pointer, match compare and result register. Uses mtf_pkg and mtf_ram.
module mtf_datapath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mtf_pkg::t_mtf_cmd               i_cmd,
    input  logic [mtf_pkg::VALUE_W-1:0]     i_value,
    output mtf_pkg::t_mtf_stat              o_stat,
    output logic [mtf_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic [mtf_pkg::OUT_TUSER_W-1:0] o_tuser
);
    import mtf_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [DATA_WIDTH-1:0] r_head;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_pos;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic [OUT_TUSER_W-1:0] r_tuser;

    logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
    logic [CW-1:0]                 count_m1;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [DATA_WIDTH-1:0]         wr_data;
    logic [DATA_WIDTH-1:0]         rd_data;
    logic [DATA_WIDTH-1:0]         head_sel;
    logic [DATA_WIDTH+HEAD_W-1:0]  head_ext;
    logic [AW+POS_W-1:0]           pos_ext;
    logic [CW+COUNT_W-1:0]         count_ext;

    // Keep the low DATA_WIDTH bits of the operand, zero-extend when wider.
    assign value_ext = {{DATA_WIDTH{1'b0}}, i_value};
    assign n_value   = i_cmd.capture ? value_ext[DATA_WIDTH-1:0] : r_value;
    assign count_m1  = r_count - CW'(1);

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO:    n_idx = '0;
            IDX_ONE:     n_idx = AW'(1);
            IDX_TOP:     n_idx = count_m1[AW-1:0];
            IDX_RD_NEXT: n_idx = r_rd_addr + AW'(1);
            IDX_RD_PREV: n_idx = r_rd_addr - AW'(1);
            IDX_INC:     n_idx = r_idx + AW'(1);
            IDX_DEC:     n_idx = r_idx - AW'(1);
            default:     n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_op)
            WR_VAL_HEAD: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_value;
            end
            WR_VAL_TAIL: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
                wr_data = r_value;
            end
            WR_SHIFT_UP: begin
                wr_en   = r_rd_vld;
                wr_addr = r_rd_addr + AW'(1);
                wr_data = rd_data;
            end
            WR_SHIFT_DOWN: begin
                wr_en   = r_rd_vld;
                wr_addr = r_rd_addr - AW'(1);
                wr_data = rd_data;
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = '0;
                wr_data = rd_data;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    mtf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_idx   <= n_idx;
        if (i_cmd.rd_en) begin
            r_rd_addr <= r_idx;
        end
        // Mirror entry 0 so the head never costs a read.
        if (wr_en && (wr_addr == '0)) begin
            r_head <= wr_data;
        end
        if (i_cmd.capture) begin
            r_pos <= '0;
        end else if (i_cmd.pos_hit) begin
            r_pos <= r_rd_addr;
        end
        if (i_cmd.out_load) begin
            r_tdata <= {{OUT_PAD_W{1'b0}}, count_ext[COUNT_W-1:0],
                        head_ext[HEAD_W-1:0], pos_ext[POS_W-1:0]};
            r_tuser <= i_cmd.out_status;
        end
    end

    assign head_sel  = (r_count == '0) ? '0 : r_head;
    assign head_ext  = {{HEAD_W{1'b0}}, head_sel};
    assign pos_ext   = {{POS_W{1'b0}}, r_pos};
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == CW'(1));
    assign o_stat.count_full = (r_count == CW'(CAPACITY));
    assign o_stat.rd_vld     = r_rd_vld;
    assign o_stat.rd_match   = r_rd_vld && (rd_data == r_value);
    assign o_stat.rd_at_zero = (r_rd_addr == '0);
    assign o_stat.rd_at_last = (r_rd_addr == count_m1[AW-1:0]);

    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;

endmodule

// ===== sv/mtf_ctrl.sv =====
// Controller of the move-to-front list table: request decode and sequencing
// of scan and shift passes, input/output handshake. Uses mtf_pkg.
module mtf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic [mtf_pkg::FUNC_W-1:0]  i_func,
    input  logic                        i_m_ready,
    input  mtf_pkg::t_mtf_stat          i_stat,
    output logic                        o_s_ready,
    output logic                        o_m_valid,
    output mtf_pkg::t_mtf_cmd           o_cmd
);
    import mtf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UP   = 3'd3;
    localparam logic [2:0] S_UPW  = 3'd4;
    localparam logic [2:0] S_DOWN = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_m_valid, n_m_valid;
    t_mtf_cmd            cmd;

    always_comb begin
        n_state        = r_state;
        n_func         = r_func;
        n_status       = r_status;
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.cnt_op     = CNT_HOLD;
        cmd.out_status = r_status;
        o_s_ready      = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Take nothing while reset is applied.
                o_s_ready = i_rst_n;
                if (i_s_valid && i_rst_n) begin
                    cmd.capture = 1'b1;
                    n_func      = i_func;
                    n_status    = ST_OK;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_func)
                    F_INS_FRONT: begin
                        if (i_stat.count_full) begin
                            n_status = ST_FULL;
                        end else if (i_stat.count_zero) begin
                            cmd.wr_op  = WR_VAL_HEAD;
                            cmd.cnt_op = CNT_INC;
                        end else begin
                            cmd.idx_op = IDX_TOP;
                            n_state    = S_UP;
                        end
                    end
                    F_INS_BACK: begin
                        if (i_stat.count_full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.wr_op  = WR_VAL_TAIL;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    F_REM_FRONT: begin
                        if (i_stat.count_zero) begin
                            n_status = ST_EMPTY;
                        end else if (i_stat.count_one) begin
                            cmd.cnt_op = CNT_DEC;
                        end else begin
                            cmd.idx_op = IDX_ONE;
                            n_state    = S_DOWN;
                        end
                    end
                    F_REM_VALUE, F_SEARCH, F_MOVE: begin
                        if (i_stat.count_zero) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd.idx_op = IDX_ZERO;
                            n_state    = S_SCAN;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.rd_match) begin
                    cmd.pos_hit = 1'b1;
                    n_state     = S_DONE;
                    case (r_func)
                        F_REM_VALUE: begin
                            if (i_stat.rd_at_last) begin
                                cmd.cnt_op = CNT_DEC;
                            end else begin
                                cmd.idx_op = IDX_RD_NEXT;
                                n_state    = S_DOWN;
                            end
                        end
                        F_MOVE: begin
                            if (!i_stat.rd_at_zero) begin
                                cmd.idx_op = IDX_RD_PREV;
                                n_state    = S_UP;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (i_stat.rd_vld && i_stat.rd_at_last) begin
                    n_status = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_UP: begin
                // Each returned entry moves one place toward the back.
                cmd.wr_op = WR_SHIFT_UP;
                if (i_stat.rd_vld && i_stat.rd_at_zero) begin
                    n_state = S_UPW;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_UPW: begin
                cmd.wr_op = WR_VAL_HEAD;
                if (r_func == F_INS_FRONT) begin
                    cmd.cnt_op = CNT_INC;
                end
                n_state = S_DONE;
            end
            S_DOWN: begin
                // Each returned entry moves one place toward the front.
                cmd.wr_op = WR_SHIFT_DOWN;
                if (i_stat.rd_vld && i_stat.rd_at_last) begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid && !i_m_ready;
        if (cmd.out_load) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_status <= n_status;
    end

    assign o_m_valid = r_m_valid;
    assign o_cmd     = cmd;

endmodule

// ===== sv/move_to_front_list_table.sv =====
// Top level of the move-to-front list table.
// Instantiates mtf_ctrl and mtf_datapath; uses mtf_pkg.
//
// Keeps an ordered list of up to CAPACITY values of DATA_WIDTH bits in a
// single-port-write, single-port-read RAM and serves one request at a time:
// insert at front, insert at back, remove front, remove first match, search,
// or move first match to front (tuser selects; codes 6 and 7 do nothing and
// return ok). Matching compares the low DATA_WIDTH bits of the operand and
// scans from the front. Every request returns exactly one result: status
// (ok, not found, full, empty), the position of the first match taken before
// the request (0 when none), the head value after it (0 when the list is
// empty) and the entry count. A request runs through accept, decode and
// result load plus each scan or shift pass it runs: the RAM's one read and
// one write port move one entry per cycle, a pass first primes the read and
// then visits its entries, and reopening the front adds a step to write the
// new head. Insert back, no-ops and requests refused as full or empty run no
// pass; a search runs a scan pass, insert front a shift pass, and move to
// front a scan and a shift pass. The next request is taken as soon as the
// previous one has been written to the output register, even if that result
// has not been collected; a result waits there until taken, and the
// following request then holds in its result-load step until the register
// frees up.
// The entry store needs no clearing after reset: entries beyond the count
// are never read.
module move_to_front_list_table #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic [mtf_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // [2:0] func
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] position, [35:4] head_value, [40:36] count, [47:41] zero
    output logic [mtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [mtf_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // [1:0] status
);
    import mtf_pkg::*;

    t_mtf_cmd  cmd;
    t_mtf_stat stat;

    // Sequence each request: decode, scan, shift, then load the result.
    mtf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_func    (s_axis_tuser[FUNC_W-1:0]),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    // Hold the store, count and head; drive the result payload.
    mtf_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (s_axis_tdata[VALUE_W-1:0]),
        .o_stat  (stat),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

endmodule

// ===== sv/mtf_checker.sv =====
// Port-level checks for the move-to-front list table, bound to the top level.
// Uses mtf_pkg; sees only the top level's ports.
module mtf_checker #(
    parameter int CAPACITY = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [mtf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import mtf_pkg::*;

    logic [COUNT_W-1:0] res_count;
    logic [HEAD_W-1:0]  res_head;

    assign res_count = m_axis_tdata[POS_W+HEAD_W+COUNT_W-1:POS_W+HEAD_W];
    assign res_head  = m_axis_tdata[POS_W+HEAD_W-1:POS_W];

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (res_count == '0))
        else $error("empty status with entries held");

    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res_count == '0) && (CAPACITY < 32) |-> (res_head == '0))
        else $error("nonzero head on empty list");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
            (res_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(res_count) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind move_to_front_list_table mtf_checker #(
    .CAPACITY (CAPACITY)
) u_mtf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for move_to_front_list_table.
// Drives request transactions, predicts each result from a shadow copy of the
// list and checks the result stream field by field. Depends on mtf_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int LIST_CAP     = 16;
    localparam int RX_LONG_HOLD = 300;   // receiver hold-off that fills the block
    localparam int WATCHDOG_MAX = 2000;  // cycles without any transaction
    localparam int TAIL_CYCLES  = 40;    // settle time after the last result
    localparam int RANDOM_ITEMS = 1000;

    // Function codes the block treats as no operation
    localparam logic [FUNC_W-1:0] F_NOP_6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_NOP_7 = 3'd7;

    localparam logic [VALUE_W-1:0] V_MOST_NEG = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_MOST_POS = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] V_ALL_ONES = 32'hffff_ffff;
    localparam logic [VALUE_W-1:0] V_ZERO     = 32'h0000_0000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [HEAD_W-1:0]   head_value;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] value
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // [2:0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [3:0] position, [35:4] head, [40:36] count, pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;  // [1:0] status

    // Shadow of the list contents, front at index 0
    logic [VALUE_W-1:0] shadow_list[$];
    t_list_result       pending_results[$];
    int                 error_count = 0;

    // Idle controls, written only by the test sequence
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_long_req = 0;

    // Receiver-side state, written only by the receiver process, and the watchdog's idle counter
    int rx_hold = 0;
    int rx_long_done = 0;
    int idle_cycles = 0;

    move_to_front_list_table #(
        .CAPACITY  (LIST_CAP),
        .DATA_WIDTH(VALUE_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the shadow list and return the result it yields
    function automatic t_list_result predict_list_result(input logic [FUNC_W-1:0] fn,
                                                         input logic [VALUE_W-1:0] val);
        t_list_result res;
        int           hit;
        res = '0;
        res.status = ST_OK;
        case (fn)
            F_INS_FRONT: begin
                if (shadow_list.size() >= LIST_CAP) res.status = ST_FULL;
                else shadow_list.push_front(val);
            end
            F_INS_BACK: begin
                if (shadow_list.size() >= LIST_CAP) res.status = ST_FULL;
                else shadow_list.push_back(val);
            end
            F_REM_FRONT: begin
                if (shadow_list.size() == 0) res.status = ST_EMPTY;
                else void'(shadow_list.pop_front());
            end
            F_REM_VALUE, F_SEARCH, F_MOVE: begin
                hit = -1;
                for (int i = shadow_list.size() - 1; i >= 0; i--)
                    if (shadow_list[i] == val) hit = i;
                if (shadow_list.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.position = hit[POS_W-1:0];
                    // remove or move to front: unlink the first match; move to front puts it back at the head
                    if (fn != F_SEARCH) shadow_list.delete(hit);
                    if (fn == F_MOVE) shadow_list.push_front(val);
                end
            end
            default: ;  // unused codes leave the list alone
        endcase
        res.head_value = (shadow_list.size() == 0) ? '0 : shadow_list[0];
        res.count      = COUNT_W'(shadow_list.size());
        return res;
    endfunction

    // Offer one request transaction, hold it until accepted, record the expectation
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] val);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_list_result(fn, val));
    endtask

    // Drop valid and pause until every expected result has been collected
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request from the sequence
    always @(posedge i_clk) begin : receiver
        int nh;
        nh = rx_hold;
        if (nh > 0) nh--;
        if (nh == 0) begin
            if (rx_long_req != rx_long_done) begin
                nh = RX_LONG_HOLD;
                rx_long_done <= rx_long_req;
            end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
                nh = pick_gap();
            end
        end
        rx_hold       <= nh;
        m_axis_tready <= (nh == 0);
    end

    // Compare every result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_list_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status=%0d data=%h", m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tuser[STATUS_W-1:0] !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[0 +: POS_W] !== exp_res.position) begin
                    $error("position: expected %0d, got %0d",
                           exp_res.position, m_axis_tdata[0 +: POS_W]);
                    error_count++;
                end
                if (m_axis_tdata[POS_W +: HEAD_W] !== exp_res.head_value) begin
                    $error("head_value: expected %h, got %h",
                           exp_res.head_value, m_axis_tdata[POS_W +: HEAD_W]);
                    error_count++;
                end
                if (m_axis_tdata[POS_W + HEAD_W +: COUNT_W] !== exp_res.count) begin
                    $error("count: expected %0d, got %0d",
                           exp_res.count, m_axis_tdata[POS_W + HEAD_W +: COUNT_W]);
                    error_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
                    $error("pad: expected 0, got %h", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("move_to_front_list_table regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Every removing or searching request, and both no-op codes, on the list as it comes out of reset
    task automatic test_empty_list();
        send_request(F_REM_FRONT, V_ZERO);
        send_request(F_REM_VALUE, 32'd5);
        send_request(F_SEARCH, V_ZERO);
        send_request(F_MOVE, V_ALL_ONES);
        send_request(F_NOP_6, V_MOST_NEG);
        send_request(F_NOP_7, V_MOST_POS);
    endtask

    // Extreme values, duplicates, hits and misses for each operation
    task automatic test_basic_ops();
        send_request(F_INS_FRONT, V_MOST_NEG);
        send_request(F_INS_BACK, V_MOST_POS);
        send_request(F_INS_FRONT, V_ZERO);
        send_request(F_INS_BACK, V_ALL_ONES);
        send_request(F_INS_FRONT, V_MOST_POS);   // duplicate: first match is the head
        send_request(F_SEARCH, V_MOST_POS);
        send_request(F_SEARCH, V_ALL_ONES);
        send_request(F_SEARCH, 32'h0001_2345);
        send_request(F_MOVE, V_MOST_POS);        // head already: list unchanged
        send_request(F_MOVE, V_ALL_ONES);        // last entry to front
        send_request(F_MOVE, 32'd42);            // miss: list unchanged
        send_request(F_REM_VALUE, V_MOST_NEG);
        send_request(F_REM_VALUE, V_MOST_NEG);   // now gone
        send_request(F_NOP_6, V_ZERO);
        send_request(F_NOP_7, V_ALL_ONES);
        send_request(F_REM_FRONT, V_MOST_NEG);
    endtask

    // Fill to capacity, overflow both ends, search and worst-case move, remove the last entry, then drain to empty
    task automatic test_full_list();
        logic [VALUE_W-1:0] last_val;
        int                 n;
        n = 0;
        while (shadow_list.size() < LIST_CAP) begin
            send_request(n[0] ? F_INS_FRONT : F_INS_BACK, 32'ha5a5_0000 + n);
            n++;
        end
        send_request(F_INS_FRONT, V_ZERO);
        send_request(F_INS_BACK, V_ALL_ONES);
        last_val = shadow_list[LIST_CAP-1];
        send_request(F_SEARCH, last_val);
        send_request(F_MOVE, last_val);
        send_request(F_REM_VALUE, shadow_list[LIST_CAP-1]);
        while (shadow_list.size() > 0) send_request(F_REM_FRONT, $urandom);
        send_request(F_REM_FRONT, V_ZERO);
    endtask

    // Hold the receiver off while requests keep coming, then pause for all results
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_long_req++;
        for (int i = 0; i < 12; i++)
            send_request(i[0] ? F_SEARCH : F_INS_BACK, $urandom_range(0, 3));
        wait_results_drained();
        tx_idle_en = 1'b1;
    endtask

    // Operand: often an entry already held or a small repeating value
    function automatic logic [VALUE_W-1:0] pick_operand();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        if (k < 7) return $urandom_range(0, 7);
        if (k < 8) begin
            case ($urandom_range(0, 3))
                0:       return V_MOST_NEG;
                1:       return V_MOST_POS;
                2:       return V_ALL_ONES;
                default: return V_ZERO;
            endcase
        end
        return $urandom;
    endfunction

    // Random requests that swing the count between empty and full
    task automatic test_random_ops(input int n_items);
        bit                growing;
        int                r;
        int                sel;
        logic [FUNC_W-1:0] fn;
        growing = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i % 80 == 0) begin
                sel = $urandom_range(0, 3);
                tx_idle_en = sel[0];
                rx_idle_en = sel[1];
            end
            if (i == n_items / 2) rx_long_req++;
            if (i > 0 && i % 300 == 0) wait_results_drained();
            // flip direction at the ends, sometimes early, sometimes staying at the end
            if (growing && shadow_list.size() == LIST_CAP && $urandom_range(0, 99) < 20)
                growing = 1'b0;
            else if (!growing && shadow_list.size() == 0 && $urandom_range(0, 99) < 20)
                growing = 1'b1;
            else if ($urandom_range(0, 99) < 2)
                growing = !growing;
            r = $urandom_range(0, 99);
            if (r < 4)                    fn = r[0] ? F_NOP_7 : F_NOP_6;
            else if (r < (growing ? 35 : 12)) fn = F_INS_FRONT;
            else if (r < (growing ? 60 : 22)) fn = F_INS_BACK;
            else if (r < (growing ? 68 : 45)) fn = F_REM_FRONT;
            else if (r < (growing ? 76 : 65)) fn = F_REM_VALUE;
            else if (r < (growing ? 88 : 82)) fn = F_SEARCH;
            else                          fn = F_MOVE;
            send_request(fn, pick_operand());
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_backpressure();
        test_random_ops(RANDOM_ITEMS);

        // let the last results arrive, then watch for stray ones
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("move_to_front_list_table regression: pass");
        end else begin
            $display("move_to_front_list_table regression: fail");
        end
        $finish;
    end

endmodule
